/* rtl/sqpi_pkg.sv */
// ----------------------------------------------------------------------------
// sqpi_pkg
// Shared types, constants and helpers for the systolic QR pivot index block.
// ----------------------------------------------------------------------------
package sqpi_pkg;

	localparam int unsigned MAX_TILE_ROWS = 1024;
	localparam int unsigned MAX_GROUP     = 64;

	// Shared divider: 12-bit padded dividend, 13-bit divisor, two bits per cycle.
	localparam int unsigned DIV_N_W   = 12;
	localparam int unsigned DIV_DVS_W = 13;
	localparam int unsigned DIV_CNT_W = 3;

	typedef enum logic [1:0] {
		KIND_TS    = 2'd0,
		KIND_LOCAL = 2'd1,
		KIND_DIST  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_FIRST_LEVEL  = 2'd0,
		REG_SECOND_LEVEL = 2'd1,
		REG_TILE_ROWS    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LAUNCH,
		S_WAIT,
		S_FIN
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_KILL_M,
		OP_KILL_ST,
		OP_RP,
		OP_WRAP,
		OP_SPAN
	} div_op_t;

	typedef struct packed {
		logic        start;
		logic [10:0] dividend;
		logic [12:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [10:0] quotient;
		logic [10:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [9:0]  k;
		logic [9:0]  pv;
		logic [10:0] st;
		logic [10:0] mt;
		logic [6:0]  p;
		logic [12:0] pq;
		logic [10:0] ks;
		logic [9:0]  r3;
		logic [12:0] jp;
	} eval_in_t;

	typedef struct packed {
		logic [10:0] next_row;
		logic        next_error;
		logic [10:0] prev_row;
		logic        prev_error;
	} eval_out_t;

	// Elimination kind of row x in panel k.
	function automatic kind_t kind_of(logic [9:0] k, logic [10:0] x, logic [6:0] p,
			logic [12:0] pq);
		logic [13:0] kp;
		logic [13:0] kpq;
		logic [13:0] xe;
		kind_t       kind;
		kp  = {4'b0, k} + {7'b0, p};
		kpq = {4'b0, k} + {1'b0, pq};
		xe  = {3'b0, x};
		if (xe >= kpq) begin
			kind = KIND_TS;
		end else if (xe >= kp) begin
			kind = KIND_LOCAL;
		end else begin
			kind = KIND_DIST;
		end
		return kind;
	endfunction

endpackage

/* rtl/systolic_qr_pivot_index.sv */
// ----------------------------------------------------------------------------
// systolic_qr_pivot_index
// Each accepted request word runs five divisions in turn on one shared
// two-bit-per-cycle divider, then resolves its result word; no new request is
// accepted until the sequencer returns to idle after loading the result.
// Reset: all three configuration registers return to 1; no result pending.
// ----------------------------------------------------------------------------
module systolic_qr_pivot_index (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [9:0]  panel_step,
	input  logic [9:0]  query_row,
	input  logic [9:0]  pivot_row,
	input  logic [10:0] start_row,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  row_kind,
	output logic [9:0]  row_pivot,
	output logic [10:0] panel_count,
	output logic [10:0] next_row,
	output logic        next_error,
	output logic [10:0] prev_row,
	output logic        prev_error
);
	import sqpi_pkg::*;

	logic [6:0]  fls_q, slc_q;
	logic [10:0] tr_q;
	logic [6:0]  p_cl, q_cl;
	logic [10:0] mt_cl;
	logic [12:0] pq_cl;

	logic [9:0]  k_q, m_q, pv_q;
	logic [10:0] st_q, mt_q;
	logic [6:0]  p_q, q_q;
	logic [12:0] pq_q;

	seq_state_t  state_q, state_d;
	div_op_t     op_q;
	logic        accept, start_div, cap, fin_fire;

	logic [9:0]  km_q, rp_q, r3_q;
	logic [10:0] ks_q;
	logic [12:0] jp_q;
	logic [6:0]  qm1, j_sel;
	kind_t       kind_m, kind_st;

	div_req_t    div_req;
	div_rsp_t    div_rsp;
	eval_in_t    ev_in;
	eval_out_t   ev_out;

	logic [10:0] span;
	logic [10:0] cnt_d;

	logic        rsp_valid_q;
	logic [1:0]  row_kind_q;
	logic [9:0]  row_pivot_q;
	logic [10:0] panel_count_q, next_row_q, prev_row_q;
	logic        next_error_q, prev_error_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fls_q <= 7'd1;
			slc_q <= 7'd1;
			tr_q  <= 11'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_LEVEL:  fls_q <= cfg_data[6:0];
				REG_SECOND_LEVEL: slc_q <= cfg_data[6:0];
				REG_TILE_ROWS:    tr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero group sizes act as one; oversized values saturate.
	always_comb begin
		p_cl  = (fls_q == 7'd0) ? 7'd1 : ((fls_q > 7'(MAX_GROUP)) ? 7'(MAX_GROUP) : fls_q);
		q_cl  = (slc_q == 7'd0) ? 7'd1 : ((slc_q > 7'(MAX_GROUP)) ? 7'(MAX_GROUP) : slc_q);
		mt_cl = (tr_q > 11'(MAX_TILE_ROWS)) ? 11'(MAX_TILE_ROWS) : tr_q;
		pq_cl = 13'({6'b0, p_cl} * {6'b0, q_cl});
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req_valid) state_d = S_LAUNCH;
			S_LAUNCH: state_d = S_WAIT;
			S_WAIT: begin
				if (div_rsp.done) state_d = (op_q == OP_SPAN) ? S_FIN : S_LAUNCH;
			end
			S_FIN:    if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		start_div = 1'b0;
		cap       = 1'b0;
		fin_fire  = 1'b0;
		unique case (state_q)
			S_IDLE:   req_ready = 1'b1;
			S_LAUNCH: start_div = 1'b1;
			S_WAIT:   cap       = div_rsp.done;
			S_FIN:    fin_fire  = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_KILL_M;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= OP_KILL_M;
			end else if (cap) begin
				case (op_q)
					OP_KILL_M:  op_q <= OP_KILL_ST;
					OP_KILL_ST: op_q <= OP_RP;
					OP_RP:      op_q <= OP_WRAP;
					OP_WRAP:    op_q <= OP_SPAN;
					default:    op_q <= OP_KILL_M;
				endcase
			end
		end
	end

	// Request word and clamped configuration are held for the whole item.
	always_ff @(posedge clk) begin
		if (accept) begin
			k_q  <= panel_step;
			m_q  <= query_row;
			pv_q <= pivot_row;
			st_q <= start_row;
			p_q  <= p_cl;
			q_q  <= q_cl;
			pq_q <= pq_cl;
			mt_q <= mt_cl;
		end
	end

	always_comb begin
		kind_m  = kind_of(k_q, {1'b0, m_q}, p_q, pq_q);
		kind_st = kind_of(k_q, st_q, p_q, pq_q);
	end

	// Divider operands for each operation.
	always_comb begin
		div_req.start    = start_div;
		div_req.dividend = '0;
		div_req.divisor  = pq_q;
		case (op_q)
			OP_KILL_M: begin
				div_req.dividend = (m_q >= k_q) ? {1'b0, m_q - k_q} : 11'd0;
				div_req.divisor  = (kind_m == KIND_TS) ? pq_q : {6'b0, p_q};
			end
			OP_KILL_ST: begin
				div_req.dividend = (st_q >= {1'b0, k_q}) ? (st_q - {1'b0, k_q}) : 11'd0;
				div_req.divisor  = (kind_st == KIND_TS) ? pq_q : {6'b0, p_q};
			end
			OP_RP: begin
				div_req.dividend = {1'b0, pv_q};
			end
			OP_WRAP: begin
				// Row count minus one minus the pivot's residue, folded by the group product.
				div_req.dividend = (mt_q > {1'b0, rp_q}) ? (mt_q - {1'b0, rp_q} - 11'd1) : 11'd0;
			end
			OP_SPAN: begin
				div_req.dividend = span;
				div_req.divisor  = {6'b0, p_q};
			end
			default: ;
		endcase
	end

	assign span = (mt_q > {1'b0, pv_q}) ? (mt_q - {1'b0, pv_q} - 11'd1) : 11'd0;

	sqpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		qm1   = q_q - 7'd1;
		j_sel = (div_rsp.quotient > {4'b0, qm1}) ? qm1 : div_rsp.quotient[6:0];
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			case (op_q)
				OP_KILL_M: begin
					km_q <= (kind_m == KIND_DIST) ? k_q : (div_rsp.remainder[9:0] + k_q);
				end
				OP_KILL_ST: begin
					ks_q <= (kind_st == KIND_DIST) ? {1'b0, k_q} :
						(div_rsp.remainder + {1'b0, k_q});
				end
				OP_RP:   rp_q <= div_rsp.remainder[9:0];
				OP_WRAP: r3_q <= div_rsp.remainder[9:0];
				OP_SPAN: jp_q <= 13'({6'b0, j_sel} * {6'b0, p_q});
				default: ;
			endcase
		end
	end

	always_comb begin
		ev_in.k  = k_q;
		ev_in.pv = pv_q;
		ev_in.st = st_q;
		ev_in.mt = mt_q;
		ev_in.p  = p_q;
		ev_in.pq = pq_q;
		ev_in.ks = ks_q;
		ev_in.r3 = r3_q;
		ev_in.jp = jp_q;
	end

	sqpi_eval u_eval (
		.ev_in  (ev_in),
		.ev_out (ev_out)
	);

	// Panel row count: min(group product, rows left), floored at zero.
	always_comb begin
		cnt_d = 11'd0;
		if (mt_q > {1'b0, k_q}) begin
			cnt_d = mt_q - {1'b0, k_q};
			if ({2'b0, cnt_d} > pq_q) begin
				cnt_d = pq_q[10:0];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			row_kind_q    <= kind_m;
			row_pivot_q   <= km_q;
			panel_count_q <= cnt_d;
			next_row_q    <= ev_out.next_row;
			next_error_q  <= ev_out.next_error;
			prev_row_q    <= ev_out.prev_row;
			prev_error_q  <= ev_out.prev_error;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign row_kind    = row_kind_q;
	assign row_pivot   = row_pivot_q;
	assign panel_count = panel_count_q;
	assign next_row    = next_row_q;
	assign next_error  = next_error_q;
	assign prev_row    = prev_row_q;
	assign prev_error  = prev_error_q;

endmodule

/* rtl/sqpi_div.sv */
// ----------------------------------------------------------------------------
// sqpi_div
// Shared restoring divider, two quotient bits per cycle, gives quotient and
// remainder of an 11-bit dividend by a 13-bit divisor.
// ----------------------------------------------------------------------------
module sqpi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sqpi_pkg::div_req_t  req,
	output sqpi_pkg::div_rsp_t  rsp
);
	import sqpi_pkg::*;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_N_W / 2);

	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_N_W-1:0]   rem_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [2*DIV_N_W-1:0] step1;
	logic [2*DIV_N_W-1:0] step2;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	function automatic logic [2*DIV_N_W-1:0] div_step(logic [DIV_N_W-1:0] r,
			logic [DIV_N_W-1:0] qv, logic [DIV_DVS_W-1:0] d);
		logic [DIV_DVS_W-1:0] t;
		logic [DIV_N_W-1:0]   qn;
		t  = {r, qv[DIV_N_W-1]};
		qn = {qv[DIV_N_W-2:0], 1'b0};
		if (t >= d) begin
			t     = t - d;
			qn[0] = 1'b1;
		end
		return {t[DIV_N_W-1:0], qn};
	endfunction

	always_comb begin
		step1 = div_step(rem_q, quo_q, dvs_q);
		step2 = div_step(step1[2*DIV_N_W-1:DIV_N_W], step1[DIV_N_W-1:0], dvs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= {1'b0, req.dividend};
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= step2[2*DIV_N_W-1:DIV_N_W];
			quo_q <= step2[DIV_N_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q[10:0];
	assign rsp.remainder = rem_q[10:0];

endmodule

/* rtl/sqpi_eval.sv */
// ----------------------------------------------------------------------------
// sqpi_eval
// Resolves the next and previous row searches from the divider results.
// ----------------------------------------------------------------------------
module sqpi_eval (
	input  sqpi_pkg::eval_in_t  ev_in,
	output sqpi_pkg::eval_out_t ev_out
);
	import sqpi_pkg::*;

	logic signed [15:0] k_s, pv_s, st_s, mt_s, p_s, pq_s, ks_s, r3_s, jp_s;
	logic signed [15:0] kp_s, kpq_s;
	logic signed [15:0] na_s, nb_s, nc_s, pa_s, pb_s, pc_s;
	logic signed [15:0] nres_s, pres_s;
	logic               nerr, perr, ndone, pdone, use_pv, eq_pv, st_none;
	kind_t              lp, ls;

	always_comb begin
		k_s   = $signed({6'b0, ev_in.k});
		pv_s  = $signed({6'b0, ev_in.pv});
		st_s  = $signed({5'b0, ev_in.st});
		mt_s  = $signed({5'b0, ev_in.mt});
		p_s   = $signed({9'b0, ev_in.p});
		pq_s  = $signed({3'b0, ev_in.pq});
		ks_s  = $signed({5'b0, ev_in.ks});
		r3_s  = $signed({6'b0, ev_in.r3});
		jp_s  = $signed({3'b0, ev_in.jp});
		kp_s  = k_s + p_s;
		kpq_s = k_s + pq_s;
		lp    = kind_of(ev_in.k, {1'b0, ev_in.pv}, ev_in.p, ev_in.pq);
		ls    = kind_of(ev_in.k, ev_in.st, ev_in.p, ev_in.pq);
		// A start at or past the row count has no kind of its own.
		st_none = (st_s >= mt_s);

		// Next row killed by the pivot.
		nerr   = 1'b1;
		nres_s = mt_s;
		ndone  = 1'b0;
		use_pv = (st_s == mt_s);
		na_s   = '0;
		nb_s   = '0;
		nc_s   = '0;
		if ((st_s > pv_s) && (pv_s >= k_s) && ((st_s == mt_s) || (pv_s == ks_s))) begin
			nerr = 1'b0;
			if (st_none && (lp == KIND_TS)) begin
				nerr  = (st_s != mt_s);
				ndone = 1'b1;
			end
			if (!ndone && (st_none || (ls == KIND_TS))) begin
				na_s = (use_pv ? pv_s : st_s) + pq_s;
				if (na_s < mt_s) begin
					nres_s = na_s;
					ndone  = 1'b1;
				end else begin
					use_pv = 1'b1;
				end
			end
			if (!ndone && (st_none || (ls != KIND_DIST))) begin
				if (lp != KIND_DIST) begin
					ndone = 1'b1;
				end else begin
					nb_s = (use_pv ? pv_s : st_s) + p_s;
					if ((nb_s >= kp_s) && (nb_s < kpq_s) && (nb_s < mt_s)) begin
						nres_s = nb_s;
						ndone  = 1'b1;
					end else begin
						use_pv = 1'b1;
					end
				end
			end
			if (!ndone && (pv_s == k_s)) begin
				nc_s = (use_pv ? pv_s : st_s) + 16'sd1;
				if (nc_s < kp_s) begin
					nres_s = nc_s;
				end
			end
		end

		// Previous row killed by the pivot.
		perr   = 1'b1;
		pres_s = mt_s;
		pdone  = 1'b0;
		eq_pv  = (st_s == pv_s);
		pa_s   = '0;
		pb_s   = '0;
		pc_s   = '0;
		if ((st_s >= pv_s) && (pv_s >= k_s) && (st_s < mt_s) &&
				((st_s == pv_s) || (pv_s == ks_s))) begin
			perr = 1'b0;
			if (lp == KIND_TS) begin
				pdone = 1'b1;
			end else if (lp < ls) begin
				perr  = 1'b1;
				pdone = 1'b1;
			end
			if (!pdone && (ls == KIND_DIST)) begin
				if (pv_s == k_s) begin
					if (eq_pv) begin
						pa_s = st_s + p_s - 16'sd1;
						if ((pa_s > pv_s) && (pa_s >= mt_s)) begin
							pa_s = mt_s - 16'sd1;
						end
					end else begin
						pa_s = st_s - 16'sd1;
					end
					if ((pv_s < pa_s) && (pa_s < kp_s)) begin
						pres_s = pa_s;
						pdone  = 1'b1;
					end
				end
				eq_pv = 1'b1;
			end
			if (!pdone && (ls != KIND_TS)) begin
				if (lp == KIND_DIST) begin
					// jp is the largest multiple of P at most the rows left after the pivot, capped at (Q-1) times P.
					pb_s = eq_pv ? (pv_s + jp_s) : (st_s - p_s);
					if ((pv_s < pb_s) && (pb_s < kpq_s)) begin
						pres_s = pb_s;
						pdone  = 1'b1;
					end
				end
				eq_pv = 1'b1;
			end
			if (!pdone) begin
				pc_s = eq_pv ? (mt_s - r3_s - 16'sd1) : (st_s - pq_s);
				if (pv_s < pc_s) begin
					pres_s = pc_s;
				end
			end
		end

		ev_out.next_row   = nres_s[10:0];
		ev_out.next_error = nerr;
		ev_out.prev_row   = pres_s[10:0];
		ev_out.prev_error = perr;
	end

endmodule
